/* rtl/core/sdpf_pkg.sv */
// Shared types, register codes and saturation helper of the spring-damper force block.
`timescale 1ns / 1ps
package sdpf_pkg;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] pivot_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_a_x;
    logic signed [31:0] force_a_y;
    logic signed [31:0] force_a_z;
    logic [30:0]        spring_length;
    logic signed [31:0] spring_velocity;
    logic signed [31:0] spring_force;
    logic               zero_length;
  } out_item_t;

  localparam logic [1:0] REG_STIFFNESS = 2'd0;
  localparam logic [1:0] REG_DAMPING   = 2'd1;
  localparam logic [1:0] REG_FREE_LEN  = 2'd2;
  localparam logic [1:0] REG_INV_STEP  = 2'd3;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] res;
    if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -68'sh0_0000_0000_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

/* rtl/core/sdpf_mul.sv */
// Shared signed 33 x 33 multiplier with a registered product.
`timescale 1ns / 1ps
module sdpf_mul (
  input  logic               clk,
  input  logic signed [32:0] mul_a,
  input  logic signed [32:0] mul_b,
  output logic signed [65:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= 66'(mul_a) * 66'(mul_b);
  end

endmodule

/* rtl/core/sdpf_sqrt.sv */
// Iterative floor square root of a 64-bit value, two radicand bits per cycle.
`timescale 1ns / 1ps
module sdpf_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done_r,
  output logic [31:0] root_r
);

  logic [63:0] rad_r;
  logic [35:0] rem_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [35:0] r2;
  logic [35:0] trial;
  logic        ge;

  assign r2    = {rem_r[33:0], rad_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = (r2 >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r  <= {rad_r[61:0], 2'b00};
        rem_r  <= ge ? (r2 - trial) : r2;
        root_r <= {root_r[30:0], ge};
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/sdpf_div.sv */
// Iterative restoring divider: 32 quotient bits, one per cycle.
`timescale 1ns / 1ps
module sdpf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [32:0] den,
  output logic        done_r,
  output logic [31:0] quot_r
);

  // The caller guarantees num < den * 2^32, so the upper half is already
  // a valid partial remainder.
  logic [32:0] rem_r;
  logic [31:0] nlo_r;
  logic [32:0] den_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [33:0] t;
  logic        ge;

  assign t  = {rem_r, nlo_r[31]};
  assign ge = (t >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= {1'b0, num[63:32]};
        nlo_r  <= num[31:0];
        den_r  <= den;
        quot_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= ge ? 33'(t - {1'b0, den_r}) : t[32:0];
        nlo_r  <= {nlo_r[30:0], 1'b0};
        quot_r <= {quot_r[30:0], ge};
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/spring_damper_pivot_force.sv */
// Spring-damper force between two body pivots: sequencer around shared arithmetic units.
//
// Usage: send one pose beat for body A (req_type 0), then one for body B
// (req_type 1) on the in_ channel. An A beat rotates A's pivot into the world
// frame and stores it; it produces no result. A B beat does the same for B,
// then computes length, velocity, scalar force and the force vector on A, and
// delivers one result beat on the out_ channel.
// Sequencing: in_ready is high only while the sequencer is idle. An A beat keeps the
// block busy for the quaternion products and the pivot rotation on the single
// shared multiplier (one product every cycle); a B beat adds the squared distance,
// the bit-serial square root, the velocity and force products and, unless the
// pivots coincide, three divisions for the force vector.
// A finished result sits in the output register until taken; the next item is
// accepted meanwhile, and a second result waits in the last step until the
// receiver frees the register.
// Reset: registers take their reset values (inv_step_time 1000 per second), the stored
// A pivot and previous length clear, and no result is pending. The user must write
// configuration through the APB-style port while the block is idle (not enforced).
`timescale 1ns / 1ps
module spring_damper_pivot_force #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sdpf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sdpf_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sdpf_pkg::*;

  localparam logic [63:0] INV_DEF_WIDE = 64'd1000 << FRAC_BITS;
  localparam logic [30:0] INV_DEFAULT =
    (INV_DEF_WIDE > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : INV_DEF_WIDE[30:0];

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_QP   = 4'd1;
  localparam logic [3:0] S_ROT  = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_VEL  = 4'd5;
  localparam logic [3:0] S_TK   = 4'd6;
  localparam logic [3:0] S_TC   = 4'd7;
  localparam logic [3:0] S_FMUL = 4'd8;
  localparam logic [3:0] S_FDIV = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0]         state_r;
  logic [3:0]         idx_r;
  in_item_t           item_r;
  logic signed [63:0] qp_r [10];
  logic signed [65:0] acc_r;
  logic [1:0]         ccol_r;
  logic [1:0]         crow_r;
  logic signed [31:0] pa_r [3];
  logic signed [31:0] pb_r [3];
  logic [65:0]        sum_r;
  logic [32:0]        len_r;
  logic signed [31:0] vel_r;
  logic signed [65:0] tk_r;
  logic signed [31:0] force_r;
  logic [1:0]         comp_r;
  logic               neg_r;
  logic [63:0]        mag_r;
  logic signed [31:0] fv_r [3];
  logic [30:0]        prev_r;
  logic [30:0]        stiff_r;
  logic [30:0]        damp_r;
  logic [30:0]        free_len_r;
  logic [30:0]        inv_step_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_r;
  logic signed [65:0] qm;
  logic signed [67:0] e [10];
  logic signed [31:0] mflat [9];
  logic signed [32:0] d [3];
  logic [30:0]        lsat;
  logic signed [32:0] len_diff;
  logic signed [32:0] free_diff;
  logic signed [31:0] org;
  logic signed [65:0] neg_prod;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [31:0]        sqrt_root;
  logic               sqrt_shift;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_quot;
  logic               cfg_we;

  sdpf_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  sdpf_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_shift ? sum_r[65:2] : sum_r[63:0]),
    .done_r   (sqrt_done),
    .root_r   (sqrt_root)
  );

  sdpf_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (mag_r),
    .den    (len_r),
    .done_r (div_done),
    .quot_r (div_quot)
  );

  assign qm         = prod_r >>> FRAC_BITS;
  assign neg_prod   = -prod_r;
  assign sqrt_shift = (sum_r[65:64] != 2'b00);
  assign sqrt_start = (state_r == S_SQRT) && (idx_r == 4'd0);
  assign div_start  = (state_r == S_FDIV) && (idx_r == 4'd0);
  assign lsat       = (len_r[32:31] != 2'b00) ? 31'h7FFF_FFFF : len_r[30:0];
  assign len_diff   = $signed({2'b00, lsat}) - $signed({2'b00, prev_r});
  assign free_diff  = $signed({2'b00, lsat}) - $signed({2'b00, free_len_r});

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      e[i] = 68'(qp_r[i]);
    end
    for (int i = 0; i < 3; i++) begin
      d[i] = 33'(pa_r[i]) - 33'(pb_r[i]);
    end
  end

  // Rotation matrix from the quaternion products: ww xx yy zz xy xz yz wx wy wz.
  always_comb begin
    mflat[0] = sat32(e[0] + e[1] - e[2] - e[3]);
    mflat[1] = sat32((e[4] - e[9]) <<< 1);
    mflat[2] = sat32((e[5] + e[8]) <<< 1);
    mflat[3] = sat32((e[4] + e[9]) <<< 1);
    mflat[4] = sat32(e[0] - e[1] + e[2] - e[3]);
    mflat[5] = sat32((e[6] - e[7]) <<< 1);
    mflat[6] = sat32((e[5] - e[8]) <<< 1);
    mflat[7] = sat32((e[6] + e[7]) <<< 1);
    mflat[8] = sat32(e[0] - e[1] - e[2] + e[3]);
  end

  always_comb begin
    unique case (crow_r)
      2'd0:    org = item_r.origin_x;
      2'd1:    org = item_r.origin_y;
      default: org = item_r.origin_z;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_QP: begin
        unique case (idx_r)
          4'd0: begin mul_a = 33'(item_r.quat_w); mul_b = 33'(item_r.quat_w); end
          4'd1: begin mul_a = 33'(item_r.quat_x); mul_b = 33'(item_r.quat_x); end
          4'd2: begin mul_a = 33'(item_r.quat_y); mul_b = 33'(item_r.quat_y); end
          4'd3: begin mul_a = 33'(item_r.quat_z); mul_b = 33'(item_r.quat_z); end
          4'd4: begin mul_a = 33'(item_r.quat_x); mul_b = 33'(item_r.quat_y); end
          4'd5: begin mul_a = 33'(item_r.quat_x); mul_b = 33'(item_r.quat_z); end
          4'd6: begin mul_a = 33'(item_r.quat_y); mul_b = 33'(item_r.quat_z); end
          4'd7: begin mul_a = 33'(item_r.quat_w); mul_b = 33'(item_r.quat_x); end
          4'd8: begin mul_a = 33'(item_r.quat_w); mul_b = 33'(item_r.quat_y); end
          4'd9: begin mul_a = 33'(item_r.quat_w); mul_b = 33'(item_r.quat_z); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_ROT: begin
        unique case (idx_r)
          4'd0: begin mul_a = 33'(mflat[0]); mul_b = 33'(item_r.pivot_x); end
          4'd1: begin mul_a = 33'(mflat[1]); mul_b = 33'(item_r.pivot_y); end
          4'd2: begin mul_a = 33'(mflat[2]); mul_b = 33'(item_r.pivot_z); end
          4'd3: begin mul_a = 33'(mflat[3]); mul_b = 33'(item_r.pivot_x); end
          4'd4: begin mul_a = 33'(mflat[4]); mul_b = 33'(item_r.pivot_y); end
          4'd5: begin mul_a = 33'(mflat[5]); mul_b = 33'(item_r.pivot_z); end
          4'd6: begin mul_a = 33'(mflat[6]); mul_b = 33'(item_r.pivot_x); end
          4'd7: begin mul_a = 33'(mflat[7]); mul_b = 33'(item_r.pivot_y); end
          4'd8: begin mul_a = 33'(mflat[8]); mul_b = 33'(item_r.pivot_z); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_SQ: begin
        unique case (idx_r)
          4'd0: begin mul_a = d[0]; mul_b = d[0]; end
          4'd1: begin mul_a = d[1]; mul_b = d[1]; end
          4'd2: begin mul_a = d[2]; mul_b = d[2]; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_VEL: begin
        mul_a = len_diff;
        mul_b = $signed({2'b00, inv_step_r});
      end
      S_TK: begin
        mul_a = free_diff;
        mul_b = $signed({2'b00, stiff_r});
      end
      S_TC: begin
        mul_a = 33'(vel_r);
        mul_b = $signed({2'b00, damp_r});
      end
      S_FMUL: begin
        mul_a = 33'(force_r);
        unique case (comp_r)
          2'd0:    mul_b = d[0];
          2'd1:    mul_b = d[1];
          default: mul_b = d[2];
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      stiff_r     <= '0;
      damp_r      <= '0;
      free_len_r  <= '0;
      inv_step_r  <= INV_DEFAULT;
      for (int i = 0; i < 3; i++) begin
        pa_r[i] <= '0;
      end
    end else begin
      // The last step reloads the valid flag itself when it delivers a beat.
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            idx_r   <= '0;
            state_r <= S_QP;
          end
        end
        S_QP: begin
          if (idx_r != 4'd0) begin
            qp_r[idx_r - 4'd1] <= qm[63:0];
          end
          if (idx_r == 4'd10) begin
            idx_r   <= '0;
            acc_r   <= '0;
            ccol_r  <= '0;
            crow_r  <= '0;
            state_r <= S_ROT;
          end else begin
            idx_r <= idx_r + 4'd1;
          end
        end
        S_ROT: begin
          if (idx_r != 4'd0) begin
            if (ccol_r == 2'd2) begin
              if (item_r.req_type) begin
                pb_r[crow_r] <= sat32(68'(acc_r) + 68'(qm) + 68'(org));
              end else begin
                pa_r[crow_r] <= sat32(68'(acc_r) + 68'(qm) + 68'(org));
              end
              acc_r  <= '0;
              ccol_r <= '0;
              crow_r <= crow_r + 2'd1;
            end else begin
              acc_r  <= acc_r + qm;
              ccol_r <= ccol_r + 2'd1;
            end
          end
          if (idx_r == 4'd9) begin
            idx_r   <= '0;
            sum_r   <= '0;
            state_r <= item_r.req_type ? S_SQ : S_IDLE;
          end else begin
            idx_r <= idx_r + 4'd1;
          end
        end
        S_SQ: begin
          if (idx_r != 4'd0) begin
            sum_r <= sum_r + prod_r[65:0];
          end
          if (idx_r == 4'd3) begin
            idx_r   <= '0;
            state_r <= S_SQRT;
          end else begin
            idx_r <= idx_r + 4'd1;
          end
        end
        S_SQRT: begin
          if (idx_r == 4'd0) begin
            idx_r <= 4'd1;
          end else if (sqrt_done) begin
            len_r   <= sqrt_shift ? {sqrt_root, 1'b0} : {1'b0, sqrt_root};
            idx_r   <= '0;
            state_r <= S_VEL;
          end
        end
        S_VEL: begin
          if (idx_r == 4'd0) begin
            idx_r <= 4'd1;
          end else begin
            vel_r   <= sat32(68'(qm));
            idx_r   <= '0;
            state_r <= S_TK;
          end
        end
        S_TK: begin
          if (idx_r == 4'd0) begin
            idx_r <= 4'd1;
          end else begin
            tk_r    <= qm;
            idx_r   <= '0;
            state_r <= S_TC;
          end
        end
        S_TC: begin
          if (idx_r == 4'd0) begin
            idx_r <= 4'd1;
          end else begin
            force_r <= sat32(-68'(tk_r) - 68'(qm));
            comp_r  <= '0;
            idx_r   <= '0;
            state_r <= S_FMUL;
          end
        end
        S_FMUL: begin
          if (idx_r == 4'd0) begin
            idx_r <= 4'd1;
          end else if (len_r == '0) begin
            // Coinciding pivots: no direction, so no force vector.
            fv_r[comp_r] <= '0;
            idx_r        <= '0;
            if (comp_r == 2'd2) begin
              state_r <= S_OUT;
            end else begin
              comp_r <= comp_r + 2'd1;
            end
          end else begin
            neg_r   <= prod_r[65];
            mag_r   <= prod_r[65] ? neg_prod[63:0] : prod_r[63:0];
            idx_r   <= '0;
            state_r <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (idx_r == 4'd0) begin
            idx_r <= 4'd1;
          end else if (div_done) begin
            // The quotient never exceeds 2^31, so only the positive side clips.
            if (neg_r) begin
              fv_r[comp_r] <= 32'(-$signed({1'b0, div_quot}));
            end else begin
              fv_r[comp_r] <= div_quot[31] ? 32'sh7FFF_FFFF : $signed(div_quot);
            end
            idx_r <= '0;
            if (comp_r == 2'd2) begin
              state_r <= S_OUT;
            end else begin
              comp_r  <= comp_r + 2'd1;
              state_r <= S_FMUL;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r.force_a_x       <= fv_r[0];
            out_r.force_a_y       <= fv_r[1];
            out_r.force_a_z       <= fv_r[2];
            out_r.spring_length   <= lsat;
            out_r.spring_velocity <= vel_r;
            out_r.spring_force    <= force_r;
            out_r.zero_length     <= (len_r == '0);
            out_valid_r           <= 1'b1;
            prev_r                <= lsat;
            state_r               <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        unique case (paddr[3:2])
          REG_STIFFNESS: stiff_r <= pwdata[30:0];
          REG_DAMPING:   damp_r  <= pwdata[30:0];
          REG_FREE_LEN: begin
            free_len_r <= pwdata[30:0];
            prev_r     <= pwdata[30:0];
          end
          default:       inv_step_r <= pwdata[30:0];
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_STIFFNESS: prdata = {1'b0, stiff_r};
      REG_DAMPING:   prdata = {1'b0, damp_r};
      REG_FREE_LEN:  prdata = {1'b0, free_len_r};
      default:       prdata = {1'b0, inv_step_r};
    endcase
  end

  assign pready    = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* dv/spring_damper_pivot_force_tb.sv */
// Self-checking testbench of the spring-damper pivot force block.
`timescale 1ns / 1ps
module spring_damper_pivot_force_tb;
  import sdpf_pkg::*;

  class force_scoreboard;
    logic [30:0] k_reg, c_reg, l0_reg, inv_reg;
    longint pa[3];
    longint prev_len;
    out_item_t force_q[$];
    int errors;

    function void clear();
      k_reg = '0;
      c_reg = '0;
      l0_reg = '0;
      inv_reg = 31'd65536000;
      pa[0] = 0;
      pa[1] = 0;
      pa[2] = 0;
      prev_len = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_STIFFNESS: k_reg = val[30:0];
        REG_DAMPING:   c_reg = val[30:0];
        REG_FREE_LEN: begin
          l0_reg = val[30:0];
          prev_len = longint'(val[30:0]);
        end
        REG_INV_STEP:  inv_reg = val[30:0];
        default: ;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint fx_mul(longint a, longint b);
      return (a * b) >>> 16;
    endfunction

    function logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function void world_pivot(in_item_t it, output longint p[3]);
      longint w, x, y, z, ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
      longint m[3][3];
      longint pv[3], org[3];
      w = it.quat_w; x = it.quat_x; y = it.quat_y; z = it.quat_z;
      ww = fx_mul(w, w); xx = fx_mul(x, x); yy = fx_mul(y, y); zz = fx_mul(z, z);
      xy = fx_mul(x, y); xz = fx_mul(x, z); yz = fx_mul(y, z);
      wx = fx_mul(w, x); wy = fx_mul(w, y); wz = fx_mul(w, z);
      m[0][0] = sat(ww + xx - yy - zz);
      m[0][1] = sat(2 * (xy - wz));
      m[0][2] = sat(2 * (xz + wy));
      m[1][0] = sat(2 * (xy + wz));
      m[1][1] = sat(ww - xx + yy - zz);
      m[1][2] = sat(2 * (yz - wx));
      m[2][0] = sat(2 * (xz - wy));
      m[2][1] = sat(2 * (yz + wx));
      m[2][2] = sat(ww - xx - yy + zz);
      pv[0] = it.pivot_x; pv[1] = it.pivot_y; pv[2] = it.pivot_z;
      org[0] = it.origin_x; org[1] = it.origin_y; org[2] = it.origin_z;
      for (int i = 0; i < 3; i++) begin
        p[i] = sat(fx_mul(m[i][0], pv[0]) + fx_mul(m[i][1], pv[1]) +
                   fx_mul(m[i][2], pv[2]) + org[i]);
      end
    endfunction

    function void note_input(in_item_t it);
      longint pb[3], d[3];
      logic [65:0] sumsq;
      logic [32:0] mag;
      logic [63:0] len;
      longint lsat, vel, tk, tc, frc;
      out_item_t e;
      if (it.req_type == 1'b0) begin
        world_pivot(it, pa);
        return;
      end
      world_pivot(it, pb);
      sumsq = '0;
      for (int i = 0; i < 3; i++) begin
        d[i] = pa[i] - pb[i];
        mag = (d[i] < 0) ? 33'(-d[i]) : 33'(d[i]);
        sumsq = sumsq + 66'(mag) * 66'(mag);
      end
      if (sumsq[65:64] == 0) len = root_floor(sumsq[63:0]);
      else len = 2 * root_floor(sumsq[65:2]);
      lsat = (len > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(len);
      vel = sat(((lsat - prev_len) * longint'(inv_reg)) >>> 16);
      tk = (longint'(k_reg) * (lsat - longint'(l0_reg))) >>> 16;
      tc = (longint'(c_reg) * vel) >>> 16;
      frc = sat(-tk - tc);
      e.force_a_x = (len == 0) ? 32'sd0 : 32'(sat((frc * d[0]) / longint'(len)));
      e.force_a_y = (len == 0) ? 32'sd0 : 32'(sat((frc * d[1]) / longint'(len)));
      e.force_a_z = (len == 0) ? 32'sd0 : 32'(sat((frc * d[2]) / longint'(len)));
      e.spring_length = 31'(lsat);
      e.spring_velocity = 32'(vel);
      e.spring_force = 32'(frc);
      e.zero_length = (len == 0);
      prev_len = lsat;
      force_q.push_back(e);
    endfunction

    function void cmp(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t r);
      out_item_t e;
      if (force_q.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
        return;
      end
      e = force_q.pop_front();
      cmp("force_a_x", e.force_a_x, r.force_a_x);
      cmp("force_a_y", e.force_a_y, r.force_a_y);
      cmp("force_a_z", e.force_a_z, r.force_a_z);
      cmp("spring_length", e.spring_length, r.spring_length);
      cmp("spring_velocity", e.spring_velocity, r.spring_velocity);
      cmp("spring_force", e.spring_force, r.spring_force);
      cmp("zero_length", e.zero_length, r.zero_length);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  force_scoreboard sb;
  int results_seen = 0;
  int stall_cnt = 0;

  always #1 clk = ~clk;

  spring_damper_pivot_force i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_val(int mode);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h8000_0000;
    if (r == 1) return 32'h7FFF_FFFF;
    if (r == 2) return 32'h0;
    if (mode == 0 || r < 6) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
  endfunction

  function automatic in_item_t rand_pose(logic kind, int mode);
    in_item_t it;
    it.req_type = kind;
    it.quat_w = (mode == 1 && $urandom_range(0, 1)) ? 32'sh0001_0000 : rand_val(mode);
    it.quat_x = rand_val(mode);
    it.quat_y = rand_val(mode);
    it.quat_z = rand_val(mode);
    it.origin_x = rand_val(mode);
    it.origin_y = rand_val(mode);
    it.origin_z = rand_val(mode);
    it.pivot_x = rand_val(mode);
    it.pivot_y = rand_val(mode);
    it.pivot_z = rand_val(mode);
    return it;
  endfunction

  function automatic in_item_t pose(logic kind, logic [31:0] qw, logic [31:0] qv,
                                    logic [31:0] org, logic [31:0] piv);
    in_item_t it;
    it = '{kind, qw, qv, qv, qv, org, org, org, piv, piv, piv};
    return it;
  endfunction

  task automatic send_beat(in_item_t it);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    in_valid = 1'b0;
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.force_q.size() != 0) @(posedge clk);
    // An A beat leaves no result, so the sequencer may still be busy.
    repeat (250) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        send_beat(rand_pose(1'b0, (r < 5) ? 1 : 0));
        send_beat(rand_pose(1'b1, (r < 5) ? 1 : 0));
      end else begin
        send_beat(rand_pose(1'($urandom_range(0, 1)), $urandom_range(0, 1)));
      end
    end
  endtask

  // Receiver: random backpressure, one long hold-off so the input side backs up.
  initial begin
    bit quiet;
    quiet = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
        results_seen++;
      end
      @(negedge clk);
      if (results_seen == 60) begin
        out_ready = 1'b0;
        repeat (600) @(posedge clk);
        results_seen++;
        @(negedge clk);
      end
      if ($urandom_range(0, 49) == 0) quiet = ~quiet;
      if (quiet) out_ready = 1'b1;
      else out_ready = (idle_len() == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0] one;
    one = 32'h0001_0000;
    sb = new();
    sb.clear();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Body B before any body A uses the cleared A pivot.
    send_beat(pose(1'b1, one, 32'h0, 32'h0003_0000, 32'h0001_0000));
    // Coinciding pivots.
    send_beat(pose(1'b0, one, 32'h0, 32'h0001_0000, 32'h0002_0000));
    send_beat(pose(1'b1, one, 32'h0, 32'h0001_0000, 32'h0002_0000));
    // Repeated A beats: the latest one counts.
    send_beat(pose(1'b0, one, 32'h0, 32'h0, 32'h0));
    send_beat(pose(1'b0, one, 32'h0, 32'h0005_0000, 32'h0));
    send_beat(pose(1'b1, one, 32'h0, 32'hFFFF_0000, 32'h0));
    // Extremes: saturated pivots and the longest possible spring.
    send_beat(pose(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_beat(pose(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    send_beat(pose(1'b0, one, 32'h0, 32'h7FFF_FFFF, 32'h0));
    send_beat(pose(1'b1, one, 32'h0, 32'h8000_0000, 32'h0));
    send_beat(pose(1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_beat(pose(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // Non-unit quaternion scales the pivot.
    send_beat(pose(1'b0, 32'h0002_0000, 32'h0, 32'h0, 32'h0001_0000));
    send_beat(pose(1'b1, 32'h0000_8000, 32'h0000_8000, 32'h0, 32'h0001_0000));
    random_phase(70);
    drain();

    write_cfg(REG_STIFFNESS, 32'h0001_0000);
    write_cfg(REG_DAMPING, 32'h0000_1000);
    write_cfg(REG_FREE_LEN, 32'h0002_0000);
    write_cfg(REG_INV_STEP, 32'd65536000);
    send_beat(pose(1'b0, one, 32'h0, 32'h0002_0000, 32'h0));
    send_beat(pose(1'b1, one, 32'h0, 32'h0, 32'h0));
    send_beat(pose(1'b1, one, 32'h0, 32'h0, 32'h0));
    random_phase(180);
    drain();

    write_cfg(REG_STIFFNESS, 32'hFFFF_FFFF);
    write_cfg(REG_DAMPING, 32'h7FFF_FFFF);
    write_cfg(REG_FREE_LEN, 32'h7FFF_FFFF);
    write_cfg(REG_INV_STEP, 32'h7FFF_FFFF);
    random_phase(180);
    drain();

    write_cfg(REG_STIFFNESS, 32'h0);
    write_cfg(REG_DAMPING, 32'h0000_0100);
    write_cfg(REG_FREE_LEN, 32'h0);
    write_cfg(REG_INV_STEP, 32'h0000_0001);
    random_phase(180);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      write_cfg(REG_STIFFNESS, $urandom);
      write_cfg(REG_DAMPING, $urandom_range(0, 32'h0010_0000));
      write_cfg(REG_FREE_LEN, $urandom_range(0, 32'h0040_0000));
      write_cfg(REG_INV_STEP, $urandom_range(1, 32'h7FFF_FFFF));
      random_phase(140);
      drain();
    end

    if (sb.errors == 0 && sb.force_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
